// ===== hw/rtl/fbpa_pkg.sv =====
// Shared types, widths and codes for the fixed block pool allocator.
package fbpa_pkg;

	localparam int BASE_W      = 32;
	localparam int BB_W        = 17;
	localparam int CNT_W       = 7;
	localparam int KIND_W      = 2;
	localparam int STAT_W      = 2;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int ROW_BITS    = 32;
	localparam int POS_W       = 5;
	localparam int SCAN_W      = CNT_W - POS_W;
	localparam int QUOT_W      = CNT_W;
	localparam int STEP_W      = 3;
	localparam int SPAN_W      = BB_W + CNT_W;

	localparam logic [BASE_W-1:0] BASE_RESET = '0;
	localparam logic [BB_W-1:0]   BB_RESET   = 17'd4096;
	localparam logic [CNT_W-1:0]  NBLK_RESET = 7'd64;

	localparam int DEF_MAX_BLOCKS = 64;
	localparam int DEF_ADDR_BITS  = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_CHECK   = 2'd2,
		KIND_UNKNOWN = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK           = 2'd0,
		ST_EMPTY        = 2'd1,
		ST_OUTSIDE      = 2'd2,
		ST_ALREADY_FREE = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POOL_BASE   = 2'd0,
		CFG_BLOCK_BYTES = 2'd1,
		CFG_BLOCKS      = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_RANGE,
		S_DIV,
		S_RD,
		S_REL,
		S_SCAN_RD,
		S_SCAN,
		S_MUL,
		S_SUM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic range_chk;
		logic div_start;
		logic take_quot;
		logic rd_idx;
		logic rd_scan;
		logic scan_next;
		logic scan_empty;
		logic alloc_commit;
		logic rel_commit;
		logic mul;
		logic sum;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  in_pool;
		logic  div_done;
		logic  scan_found;
		logic  scan_last;
	} stat_t;

endpackage

// ===== hw/rtl/fbpa_div.sv =====
// Restoring divider that yields the block index, one quotient bit per cycle.
module fbpa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fbpa_pkg::BASE_W-1:0] dividend,
	input  logic [fbpa_pkg::BB_W-1:0]   divisor,
	output logic                        done,
	output logic [fbpa_pkg::QUOT_W-1:0] quotient
);
	import fbpa_pkg::*;

	logic [BASE_W-1:0] rem_q;
	logic [QUOT_W-1:0] quot_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [BASE_W-1:0] trial;

	assign trial = BASE_W'(divisor) << step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && step_q == '0) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			quot_q <= '0;
			step_q <= STEP_W'(QUOT_W - 1);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q          <= rem_q - trial;
				quot_q[step_q] <= 1'b1;
			end
			step_q <= step_q - STEP_W'(1);
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ===== hw/rtl/fbpa_dp.sv =====
// Datapath: configuration, used map memory, range check, index math and result registers.
module fbpa_dp #(
	parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS,
	parameter int ADDR_BITS  = fbpa_pkg::DEF_ADDR_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbpa_pkg::CFG_W-1:0]     cfg_data,
	input  logic [fbpa_pkg::KIND_W-1:0]    kind,
	input  logic [fbpa_pkg::BASE_W-1:0]    address,
	input  fbpa_pkg::cmd_t                 cmd,
	output fbpa_pkg::stat_t                stat,
	output logic [fbpa_pkg::BASE_W-1:0]    block_address,
	output logic [fbpa_pkg::STAT_W-1:0]    status,
	output logic                           inside_pool,
	output logic [fbpa_pkg::CNT_W-1:0]     blocks_used
);
	import fbpa_pkg::*;

	localparam int ROWS      = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [CNT_W-1:0] MAX_CLAMP =
		(MAX_BLOCKS >= (1 << CNT_W)) ? '1 : CNT_W'(MAX_BLOCKS);

	logic [BASE_W-1:0] pool_base_q;
	logic [BB_W-1:0]   block_bytes_q;
	logic [CNT_W-1:0]  blocks_in_pool_q;

	kind_t             kind_q;
	logic [BASE_W-1:0] addr_q;
	logic [BB_W-1:0]   eff_bb_q;
	logic [CNT_W-1:0]  eff_n_q;
	logic [SPAN_W-1:0] span_q;
	logic              below_q;
	logic [BASE_W-1:0] diff_q;
	logic [QUOT_W-1:0] idx_q;
	logic [SCAN_W-1:0] scan_row_q;
	logic [SPAN_W-1:0] prod_q;
	logic [CNT_W-1:0]  used_count_q;

	logic [BASE_W-1:0] res_addr_q;
	status_t           res_status_q;
	logic              res_inside_q;

	logic [BASE_W-1:0] out_addr_q;
	status_t           out_status_q;
	logic              out_inside_q;
	logic [CNT_W-1:0]  out_used_q;

	logic [ROW_BITS-1:0] map_mem [ROWS];
	logic [ROWS-1:0]     row_vld_q;
	logic [ROW_BITS-1:0] rd_q;
	logic                rd_vld_q;

	logic [BB_W-1:0]      eff_bb_c;
	logic [CNT_W-1:0]     eff_n_c;
	logic [BASE_W-1:0]    base_c;
	logic                 inside_c;
	logic [ROW_BITS-1:0]  row_c;
	logic [ROW_BITS-1:0]  avail_c;
	logic                 found_c;
	logic [POS_W-1:0]     found_pos_c;
	logic [CNT_W:0]       next_start_c;
	logic                 last_c;
	logic                 bit_used_c;
	logic                 div_done;
	logic [QUOT_W-1:0]    quot;

	logic                 mem_we;
	logic [ROW_IDX_W-1:0] mem_wa;
	logic [ROW_BITS-1:0]  mem_wd;
	logic                 mem_re;
	logic [ROW_IDX_W-1:0] mem_ra;

	assign eff_bb_c = (block_bytes_q == '0) ? BB_W'(1) : block_bytes_q;
	assign eff_n_c  = (blocks_in_pool_q > MAX_CLAMP) ? MAX_CLAMP : blocks_in_pool_q;
	assign base_c   = BASE_W'(ADDR_BITS'(pool_base_q));
	assign inside_c = !below_q && (diff_q < BASE_W'(span_q));
	assign row_c    = rd_vld_q ? rd_q : '0;

	always_comb begin
		for (int j = 0; j < ROW_BITS; j++) begin
			avail_c[j] = !row_c[j] && ({scan_row_q, POS_W'(j)} < eff_n_q);
		end
		found_c     = 1'b0;
		found_pos_c = '0;
		for (int j = ROW_BITS - 1; j >= 0; j--) begin
			if (avail_c[j]) begin
				found_c     = 1'b1;
				found_pos_c = POS_W'(j);
			end
		end
	end

	assign next_start_c = {({1'b0, scan_row_q} + (SCAN_W + 1)'(1)), POS_W'(0)};
	assign last_c       = next_start_c >= {1'b0, eff_n_q};
	assign bit_used_c   = row_c[idx_q[POS_W-1:0]];

	always_comb begin
		mem_we = 1'b0;
		mem_wa = ROW_IDX_W'(idx_q >> POS_W);
		mem_wd = row_c & ~(ROW_BITS'(1) << idx_q[POS_W-1:0]);
		mem_re = 1'b0;
		mem_ra = ROW_IDX_W'(idx_q >> POS_W);
		if (cmd.rd_idx) begin
			mem_re = 1'b1;
		end
		if (cmd.rd_scan) begin
			mem_re = 1'b1;
			mem_ra = ROW_IDX_W'(scan_row_q);
		end
		if (cmd.rel_commit && bit_used_c) begin
			mem_we = 1'b1;
		end
		if (cmd.alloc_commit) begin
			mem_we = 1'b1;
			mem_wa = ROW_IDX_W'(scan_row_q);
			mem_wd = row_c | (ROW_BITS'(1) << found_pos_c);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= map_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (mem_we) begin
				row_vld_q[mem_wa] <= 1'b1;
			end
			if (mem_re) begin
				rd_vld_q <= row_vld_q[mem_ra];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q      <= BASE_RESET;
			block_bytes_q    <= BB_RESET;
			blocks_in_pool_q <= NBLK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_POOL_BASE:   pool_base_q      <= BASE_W'(cfg_data);
				CFG_BLOCK_BYTES: block_bytes_q    <= BB_W'(cfg_data);
				CFG_BLOCKS:      blocks_in_pool_q <= CNT_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_count_q <= '0;
		end else if (cmd.alloc_commit && found_c) begin
			used_count_q <= used_count_q + CNT_W'(1);
		end else if (cmd.rel_commit && bit_used_c) begin
			used_count_q <= used_count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(kind);
			addr_q <= address;
		end
		if (cmd.prep) begin
			eff_bb_q     <= eff_bb_c;
			eff_n_q      <= eff_n_c;
			span_q       <= SPAN_W'(eff_bb_c) * SPAN_W'(eff_n_c);
			below_q      <= addr_q < base_c;
			diff_q       <= addr_q - base_c;
			scan_row_q   <= '0;
			res_addr_q   <= '0;
			res_status_q <= ST_OK;
			res_inside_q <= 1'b0;
		end
		if (cmd.range_chk) begin
			res_inside_q <= inside_c;
			if (!inside_c && kind_q == KIND_RELEASE) begin
				res_status_q <= ST_OUTSIDE;
			end
		end
		if (cmd.take_quot) begin
			idx_q <= quot;
		end
		if (cmd.scan_next) begin
			scan_row_q <= scan_row_q + SCAN_W'(1);
		end
		if (cmd.scan_empty) begin
			res_status_q <= ST_EMPTY;
		end
		if (cmd.alloc_commit) begin
			idx_q <= {scan_row_q, found_pos_c};
		end
		if (cmd.rel_commit && !bit_used_c) begin
			res_status_q <= ST_ALREADY_FREE;
		end
		if (cmd.mul) begin
			prod_q <= SPAN_W'(idx_q) * SPAN_W'(eff_bb_q);
		end
		if (cmd.sum) begin
			res_addr_q <= BASE_W'(ADDR_BITS'(pool_base_q) + ADDR_BITS'(prod_q));
		end
		if (cmd.out_load) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
			out_inside_q <= res_inside_q;
			out_used_q   <= used_count_q;
		end
	end

	fbpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (diff_q),
		.divisor  (eff_bb_q),
		.done     (div_done),
		.quotient (quot)
	);

	assign stat.kind       = kind_q;
	assign stat.in_pool    = inside_c;
	assign stat.div_done   = div_done;
	assign stat.scan_found = found_c;
	assign stat.scan_last  = last_c;

	assign block_address = out_addr_q;
	assign status        = out_status_q;
	assign inside_pool   = out_inside_q;
	assign blocks_used   = out_used_q;

endmodule

// ===== hw/rtl/fbpa_ctrl.sv =====
// Controller state machine sequencing each request and the result handshake.
module fbpa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  fbpa_pkg::stat_t stat,
	output fbpa_pkg::cmd_t  cmd
);
	import fbpa_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_PREP;
			end
			S_PREP: begin
				unique case (stat.kind)
					KIND_ALLOC:   state_d = S_SCAN_RD;
					KIND_RELEASE: state_d = S_RANGE;
					KIND_CHECK:   state_d = S_RANGE;
					KIND_UNKNOWN: state_d = S_DONE;
				endcase
			end
			S_RANGE: begin
				state_d = (stat.kind == KIND_RELEASE && stat.in_pool) ? S_DIV : S_DONE;
			end
			S_DIV: begin
				if (stat.div_done) state_d = S_RD;
			end
			S_RD:      state_d = S_REL;
			S_REL:     state_d = S_DONE;
			S_SCAN_RD: state_d = S_SCAN;
			S_SCAN: begin
				priority if (stat.scan_found) state_d = S_MUL;
				else if (stat.scan_last) state_d = S_DONE;
				else state_d = S_SCAN_RD;
			end
			S_MUL: state_d = S_SUM;
			S_SUM: state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_PREP:  cmd.prep = 1'b1;
			S_RANGE: begin
				cmd.range_chk = 1'b1;
				cmd.div_start = stat.kind == KIND_RELEASE && stat.in_pool;
			end
			S_DIV:     cmd.take_quot = stat.div_done;
			S_RD:      cmd.rd_idx = 1'b1;
			S_REL:     cmd.rel_commit = 1'b1;
			S_SCAN_RD: cmd.rd_scan = 1'b1;
			S_SCAN: begin
				cmd.alloc_commit = stat.scan_found;
				cmd.scan_empty   = !stat.scan_found && stat.scan_last;
				cmd.scan_next    = !stat.scan_found && !stat.scan_last;
			end
			S_MUL:  cmd.mul = 1'b1;
			S_SUM:  cmd.sum = 1'b1;
			S_DONE: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/fixed_block_pool_allocator_core.sv =====
// Top level of the fixed block pool allocator.
//
// Requests enter on the in channel (in_valid/in_ready) as one beat of kind and
// address; each request yields exactly one result beat on the out channel
// (out_valid/out_ready) carrying block_address, status, inside_pool and
// blocks_used. One request is worked on at a time; in_ready is high only
// while the controller is idle.
// Steps from accept to result: check and release outside the pool run
// prepare and range check; an unknown kind goes from prepare to done;
// release inside the pool adds the 7-step block-index divider, a used map
// read and the release commit; allocate reads and scans the used map one
// 32-block row at a time, then multiplies and adds for the address when a
// block is found. The controller is idle in the cycle after loading a result.
// The result sits in an output register, so the next request is accepted
// while a result still waits; a stalled receiver holds the result and the
// following request finishes and then waits for the output register.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong only to idle periods; index 3 is ignored.
// Reset clears the used map (per-row valid flops, no clearing pass), the used
// count and the handshake state, and loads the register defaults.
module fixed_block_pool_allocator_core #(
	parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS,
	parameter int ADDR_BITS  = fbpa_pkg::DEF_ADDR_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbpa_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [fbpa_pkg::KIND_W-1:0]    kind,
	input  logic [fbpa_pkg::BASE_W-1:0]    address,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [fbpa_pkg::BASE_W-1:0]    block_address,
	output logic [fbpa_pkg::STAT_W-1:0]    status,
	output logic                           inside_pool,
	output logic [fbpa_pkg::CNT_W-1:0]     blocks_used
);
	import fbpa_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fbpa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.ADDR_BITS  (ADDR_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.address       (address),
		.cmd           (cmd),
		.stat          (stat),
		.block_address (block_address),
		.status        (status),
		.inside_pool   (inside_pool),
		.blocks_used   (blocks_used)
	);

endmodule
